// ----- hw/rtl/char_lcd_shadow_refresh_macros.svh -----
// Assertion macros for the character LCD shadow refresh block.
`ifndef CHAR_LCD_SHADOW_REFRESH_MACROS_SVH
`define CHAR_LCD_SHADOW_REFRESH_MACROS_SVH

// Check a property on the rising clock edge, off while reset is asserted.
`define CLSR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CLSR_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/clsr_pkg.sv -----
// Types and constants shared by the character LCD shadow refresh block.
`default_nettype none

package clsr_pkg;

  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] LINE2_BASE      = 8'h40;
  localparam logic [7:0] DDRAM_CMD       = 8'h80;
  localparam logic [7:0] DDRAM_ADDR_MASK = 8'h7F;
  // Width of start column plus character index (covers 31 + 15).
  localparam int unsigned SUM_W = 6;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_REFRESH = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SELECT,
    S_CMD,
    S_DATA_RD,
    S_DATA_WR,
    S_STATUS
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic       line_select;
    logic [4:0] start_pos;
    logic [3:0] char_index;
    logic [7:0] data_byte;
    logic       force_full;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // Memory strobes from the sequencer; both stores share one address.
  typedef struct packed {
    logic pend_we;
    logic shown_we;
    logic rd_en;
  } mem_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/clsr_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module clsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/clsr_seq.sv -----
// Sequencer with the shared column counter and byte compare unit.
`default_nettype none

module clsr_seq #(
  parameter int unsigned LineLength = 16,
  localparam int unsigned Depth = 2 * LineLength,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned ColW  = $clog2(LineLength)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire clsr_pkg::in_item_t   in_item_i,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_data_i,
  output      clsr_pkg::mem_ctrl_t  mem_o,
  output      logic [AddrW-1:0]     addr_o,
  output      logic [7:0]           wdata_o,
  input  wire logic [7:0]           pend_byte_i,
  input  wire logic [7:0]           shown_byte_i,
  input  wire logic                 out_free_i,
  output      logic                 out_push_o,
  output      clsr_pkg::out_item_t  out_item_o
);

  localparam logic [ColW-1:0]  ColLast = ColW'(LineLength - 1);
  localparam logic [AddrW-1:0] Line2Off = AddrW'(LineLength);

  clsr_pkg::state_e  state_q, state_d;
  clsr_pkg::status_e status_q, status_d;
  logic              line_q, line_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [1:0]        need_q, need_d;
  logic [ColW-1:0]   start_q [2];
  logic [ColW-1:0]   start_d [2];
  logic              force_q, force_d;
  logic              force2_q, force2_d;
  logic              managed_q, managed_d;
  logic              was_q, was_d;

  logic                        line_done;
  logic                        line_forced;
  logic                        col_end;
  logic [AddrW-1:0]            line_off;
  logic [clsr_pkg::SUM_W-1:0]  wr_pos;
  logic [clsr_pkg::SUM_W-1:0]  wr_sum;
  logic                        wr_invalid;
  logic                        wr_trunc;
  logic [AddrW-1:0]            wr_addr;
  logic [7:0]                  cmd_byte;

  assign line_off    = line_q ? Line2Off : '0;
  assign line_forced = line_q ? force2_q : force_q;
  assign col_end     = (col_q == ColLast);

  assign wr_pos     = clsr_pkg::SUM_W'(in_item_i.start_pos);
  assign wr_sum     = wr_pos + clsr_pkg::SUM_W'(in_item_i.char_index);
  assign wr_invalid = (wr_pos >= clsr_pkg::SUM_W'(LineLength)) ||
                      (in_item_i.line_select && !managed_q);
  assign wr_trunc   = (wr_sum >= clsr_pkg::SUM_W'(LineLength));
  assign wr_addr    = (in_item_i.line_select ? Line2Off : '0) + AddrW'(wr_sum);

  assign cmd_byte = clsr_pkg::DDRAM_CMD |
                    (((line_q ? clsr_pkg::LINE2_BASE : 8'h00) + 8'(col_q)) &
                     clsr_pkg::DDRAM_ADDR_MASK);

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    line_d     = line_q;
    col_d      = col_q;
    need_d     = need_q;
    start_d    = start_q;
    force_d    = force_q;
    force2_d   = force2_q;
    managed_d  = managed_q;
    was_d      = was_q;
    line_done  = 1'b0;
    in_ready_o = 1'b0;
    mem_o      = '0;
    addr_o     = line_off + AddrW'(col_q);
    wdata_o    = pend_byte_i;
    out_push_o = 1'b0;
    out_item_o = '0;

    case (state_q)
      clsr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          line_d = in_item_i.line_select;
          col_d  = '0;
          need_d = '0;
          case (in_item_i.opcode)
            clsr_pkg::OP_WRITE: begin
              state_d = clsr_pkg::S_STATUS;
              if (wr_invalid) begin
                status_d = clsr_pkg::ST_INVALID;
              end else if (wr_trunc) begin
                status_d = clsr_pkg::ST_TRUNC;
              end else begin
                status_d      = clsr_pkg::ST_OK;
                mem_o.pend_we = 1'b1;
                addr_o        = wr_addr;
                wdata_o       = in_item_i.data_byte;
              end
            end
            clsr_pkg::OP_CLEAR: begin
              status_d = clsr_pkg::ST_OK;
              state_d  = clsr_pkg::S_CLEAR;
            end
            clsr_pkg::OP_REFRESH: begin
              line_d   = 1'b0;
              status_d = clsr_pkg::ST_OK;
              force_d  = in_item_i.force_full;
              if (managed_q && !was_q) begin
                force2_d = 1'b1;
                was_d    = 1'b1;
              end else begin
                force2_d = in_item_i.force_full;
              end
              state_d = clsr_pkg::S_SCAN_RD;
            end
            default: begin
              status_d = clsr_pkg::ST_INVALID;
              state_d  = clsr_pkg::S_STATUS;
            end
          endcase
        end
      end

      clsr_pkg::S_CLEAR: begin
        mem_o.pend_we = 1'b1;
        wdata_o       = clsr_pkg::CHAR_SPACE;
        if (col_end) begin
          state_d = clsr_pkg::S_STATUS;
        end else begin
          col_d = col_q + 1'b1;
        end
      end

      clsr_pkg::S_SCAN_RD: begin
        if (line_forced) begin
          need_d[line_q]  = 1'b1;
          start_d[line_q] = '0;
          line_done       = 1'b1;
        end else begin
          mem_o.rd_en = 1'b1;
          state_d     = clsr_pkg::S_SCAN_CMP;
        end
      end

      clsr_pkg::S_SCAN_CMP: begin
        if (pend_byte_i != shown_byte_i) begin
          need_d[line_q]  = 1'b1;
          start_d[line_q] = col_q;
          line_done       = 1'b1;
        end else if (col_end) begin
          line_done = 1'b1;
        end else begin
          col_d   = col_q + 1'b1;
          state_d = clsr_pkg::S_SCAN_RD;
        end
      end

      clsr_pkg::S_SELECT: begin
        if (need_q[0]) begin
          line_d    = 1'b0;
          col_d     = start_q[0];
          need_d[0] = 1'b0;
          state_d   = clsr_pkg::S_CMD;
        end else if (need_q[1]) begin
          line_d    = 1'b1;
          col_d     = start_q[1];
          need_d[1] = 1'b0;
          state_d   = clsr_pkg::S_CMD;
        end else begin
          state_d = clsr_pkg::S_STATUS;
        end
      end

      clsr_pkg::S_CMD: begin
        if (out_free_i) begin
          out_push_o       = 1'b1;
          out_item_o.kind  = clsr_pkg::KIND_CMD;
          out_item_o.value = cmd_byte;
          state_d          = clsr_pkg::S_DATA_RD;
        end
      end

      clsr_pkg::S_DATA_RD: begin
        mem_o.rd_en = 1'b1;
        state_d     = clsr_pkg::S_DATA_WR;
      end

      clsr_pkg::S_DATA_WR: begin
        if (out_free_i) begin
          out_push_o       = 1'b1;
          out_item_o.kind  = clsr_pkg::KIND_DATA;
          out_item_o.value = pend_byte_i;
          out_item_o.last  = col_end && (line_q || !need_q[1]);
          mem_o.shown_we   = 1'b1;
          if (col_end) begin
            state_d = (!line_q && need_q[1]) ? clsr_pkg::S_SELECT : clsr_pkg::S_IDLE;
          end else begin
            col_d   = col_q + 1'b1;
            state_d = clsr_pkg::S_DATA_RD;
          end
        end
      end

      clsr_pkg::S_STATUS: begin
        if (out_free_i) begin
          out_push_o        = 1'b1;
          out_item_o.kind   = clsr_pkg::KIND_STATUS;
          out_item_o.status = status_q;
          out_item_o.last   = 1'b1;
          state_d           = clsr_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = clsr_pkg::S_IDLE;
      end
    endcase

    // Move from the first line's scan to the second, or on to sending.
    if (line_done) begin
      col_d = '0;
      if (!line_q && managed_q) begin
        line_d  = 1'b1;
        state_d = clsr_pkg::S_SCAN_RD;
      end else begin
        state_d = clsr_pkg::S_SELECT;
      end
    end

    if (cfg_we_i) begin
      managed_d = cfg_data_i;
      if (!cfg_data_i) begin
        was_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= clsr_pkg::S_IDLE;
      status_q  <= clsr_pkg::ST_OK;
      line_q    <= 1'b0;
      col_q     <= '0;
      need_q    <= '0;
      force_q   <= 1'b0;
      force2_q  <= 1'b0;
      managed_q <= 1'b0;
      was_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      status_q  <= status_d;
      line_q    <= line_d;
      col_q     <= col_d;
      need_q    <= need_d;
      force_q   <= force_d;
      force2_q  <= force2_d;
      managed_q <= managed_d;
      was_q     <= was_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/char_lcd_shadow_refresh.sv -----
// Top level of the two-line character LCD front end with shadow refresh.
//
// Keeps a pending buffer and a shown copy of both display lines and turns
// write, clear and refresh requests into LCD command and data bytes. Each
// request is taken on in_valid_i/in_ready_o and runs to completion before the
// next is accepted; its results leave through a one-deep output register, so
// the last result of one request may still wait while the next is accepted.
// A refresh scans each line column by column up to its first changed column,
// one RAM read and then one compare in the shared unit per column, and
// skips the scan of a forced line; for each line to send it then picks the
// line, sends the address command and sends each data byte with a read,
// then a send and copy. The single read port of each buffer sets this pace,
// and a stalled output holds it. Both buffers live in RAM; valid bits,
// cleared at reset, make any unwritten entry read as a space, so no
// clearing pass is needed after reset. The line2_managed register is written
// on cfg_valid_i/cfg_ready_o; the host must write it only while no request is
// in flight, and the block itself does not enforce this. Writing 0 also
// re-arms the full redraw of line 2 on the next managed refresh.
`default_nettype none

`include "char_lcd_shadow_refresh_macros.svh"

module char_lcd_shadow_refresh #(
  parameter int unsigned LineLength = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire clsr_pkg::in_item_t  in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      clsr_pkg::out_item_t out_item_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic                cfg_data_i
);

  localparam int unsigned Depth = 2 * LineLength;
  localparam int unsigned AddrW = $clog2(Depth);

  clsr_pkg::mem_ctrl_t mem;
  logic [AddrW-1:0]    addr;
  logic [7:0]          wdata;
  logic [7:0]          pend_rdata;
  logic [7:0]          shown_rdata;
  logic [7:0]          pend_byte;
  logic [7:0]          shown_byte;
  logic                out_free;
  logic                out_push;
  clsr_pkg::out_item_t out_item;

  // Valid bits per buffer entry: an entry never written reads as a space.
  logic [Depth-1:0]    pend_vld_q;
  logic [Depth-1:0]    shown_vld_q;
  logic                pend_rvld_q;
  logic                shown_rvld_q;

  logic                out_vld_q;
  clsr_pkg::out_item_t out_item_q;

  // Always take register writes; the host must write only while idle, as the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  clsr_seq #(
    .LineLength (LineLength)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .mem_o        (mem),
    .addr_o       (addr),
    .wdata_o      (wdata),
    .pend_byte_i  (pend_byte),
    .shown_byte_i (shown_byte),
    .out_free_i   (out_free),
    .out_push_o   (out_push),
    .out_item_o   (out_item)
  );

  // Pending buffer: written by write and clear requests, read for refresh.
  clsr_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (mem.pend_we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (mem.rd_en),
    .raddr_i (addr),
    .rdata_o (pend_rdata)
  );

  // Shown copy: mirrors what has been sent to the display.
  clsr_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_shown_ram (
    .clk_i   (clk_i),
    .we_i    (mem.shown_we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (mem.rd_en),
    .raddr_i (addr),
    .rdata_o (shown_rdata)
  );

  // Mark entries valid on write; capture the valid bit alongside the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q   <= '0;
      shown_vld_q  <= '0;
      pend_rvld_q  <= 1'b0;
      shown_rvld_q <= 1'b0;
    end else begin
      if (mem.pend_we) begin
        pend_vld_q[addr] <= 1'b1;
      end
      if (mem.shown_we) begin
        shown_vld_q[addr] <= 1'b1;
      end
      if (mem.rd_en) begin
        pend_rvld_q  <= pend_vld_q[addr];
        shown_rvld_q <= shown_vld_q[addr];
      end
    end
  end

  assign pend_byte  = pend_rvld_q  ? pend_rdata  : clsr_pkg::CHAR_SPACE;
  assign shown_byte = shown_rvld_q ? shown_rdata : clsr_pkg::CHAR_SPACE;

  // Output register: hold a result until taken, refill in the same cycle.
  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_push) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_item_q <= out_item;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

  `CLSR_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "request accepted but sequencer still ready")
  `CLSR_ASSERT_NR(a_push_has_room, clk_i, out_push |-> (!out_vld_q || out_ready_i), "result pushed over a waiting result")
  `CLSR_ASSERT(a_idle_after_last, clk_i, rst_ni, $rose(in_ready_o) |-> $past(out_push && out_item.last), "sequencer idle without a final result")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the two-line character LCD shadow refresh front end.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LINE_LEN     = 16;
  localparam logic [7:0]  LINE1_BASE   = 8'h00;
  // Opcode value the block does not define; it must answer invalid.
  localparam logic [1:0]  OP_UNDEFINED = 2'd3;

  // Mirror of the block: pending and shown buffers for both lines, the
  // line 2 ownership flags, and the LCD bytes and status still owed to us.
  class lcd_shadow_scoreboard;
    logic [7:0]          pend_buf [2*LINE_LEN];
    logic [7:0]          disp_buf [2*LINE_LEN];
    bit                  line2_on;
    bit                  line2_drawn;
    clsr_pkg::out_item_t due [$];
    int                  errors;

    function new();
      foreach (pend_buf[i]) begin
        pend_buf[i] = clsr_pkg::CHAR_SPACE;
        disp_buf[i] = clsr_pkg::CHAR_SPACE;
      end
      line2_on    = 1'b0;
      line2_drawn = 1'b0;
      errors      = 0;
    endfunction

    function clsr_pkg::out_item_t make_result(clsr_pkg::kind_e k, logic [7:0] v,
                                              clsr_pkg::status_e s, logic fin);
      clsr_pkg::out_item_t r;
      r.kind   = k;
      r.value  = v;
      r.status = s;
      r.last   = fin;
      return r;
    endfunction

    function void set_managed(bit on);
      line2_on = on;
      if (!on) line2_drawn = 1'b0;
    endfunction

    function int due_count();
      return due.size();
    endfunction

    // Send one line from its first stale column (or column 0 when whole)
    // and bring the shown copy up to date.
    function void refresh_line(int unsigned line, bit whole);
      int unsigned off;
      int unsigned col;
      logic [7:0]  base;
      off  = line * LINE_LEN;
      base = (line != 0) ? clsr_pkg::LINE2_BASE : LINE1_BASE;
      col  = 0;
      if (!whole) begin
        while (col < LINE_LEN && pend_buf[off+col] == disp_buf[off+col]) col++;
        if (col == LINE_LEN) return;
      end
      due.push_back(make_result(clsr_pkg::KIND_CMD,
                                clsr_pkg::DDRAM_CMD |
                                ((base + 8'(col)) & clsr_pkg::DDRAM_ADDR_MASK),
                                clsr_pkg::ST_OK, 1'b0));
      while (col < LINE_LEN) begin
        due.push_back(make_result(clsr_pkg::KIND_DATA, pend_buf[off+col],
                                  clsr_pkg::ST_OK, 1'b0));
        disp_buf[off+col] = pend_buf[off+col];
        col++;
      end
    endfunction

    // Predict everything an accepted request will cause.
    function void note_request(clsr_pkg::in_item_t req);
      int unsigned         col;
      int unsigned         before_cnt;
      bit                  whole2;
      clsr_pkg::out_item_t tail;
      col = int'(req.start_pos) + int'(req.char_index);
      case (req.opcode)
        clsr_pkg::OP_WRITE: begin
          if (req.start_pos >= LINE_LEN || (req.line_select && !line2_on))
            due.push_back(make_result(clsr_pkg::KIND_STATUS, 8'h00,
                                      clsr_pkg::ST_INVALID, 1'b1));
          else if (col >= LINE_LEN)
            due.push_back(make_result(clsr_pkg::KIND_STATUS, 8'h00,
                                      clsr_pkg::ST_TRUNC, 1'b1));
          else begin
            pend_buf[int'(req.line_select) * LINE_LEN + col] = req.data_byte;
            due.push_back(make_result(clsr_pkg::KIND_STATUS, 8'h00,
                                      clsr_pkg::ST_OK, 1'b1));
          end
        end
        clsr_pkg::OP_CLEAR: begin
          for (int i = 0; i < LINE_LEN; i++)
            pend_buf[int'(req.line_select) * LINE_LEN + i] = clsr_pkg::CHAR_SPACE;
          due.push_back(make_result(clsr_pkg::KIND_STATUS, 8'h00,
                                    clsr_pkg::ST_OK, 1'b1));
        end
        clsr_pkg::OP_REFRESH: begin
          before_cnt = due.size();
          refresh_line(0, req.force_full);
          if (line2_on) begin
            // First refresh after taking line 2 over redraws it entirely.
            whole2 = req.force_full || !line2_drawn;
            line2_drawn = 1'b1;
            refresh_line(1, whole2);
          end
          if (due.size() == before_cnt)
            due.push_back(make_result(clsr_pkg::KIND_STATUS, 8'h00,
                                      clsr_pkg::ST_OK, 1'b1));
          else begin
            tail = due.pop_back();
            tail.last = 1'b1;
            due.push_back(tail);
          end
        end
        default: due.push_back(make_result(clsr_pkg::KIND_STATUS, 8'h00,
                                           clsr_pkg::ST_INVALID, 1'b1));
      endcase
    endfunction

    function void check_result(clsr_pkg::out_item_t got);
      clsr_pkg::out_item_t want;
      if (due.size() == 0) begin
        $error("unexpected result: kind %0d value 0x%02h status %0d last %0d",
               got.kind, got.value, got.status, got.last);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("value: expected 0x%02h, got 0x%02h", want.value, got.value);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  clsr_pkg::in_item_t  in_item   = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_data  = 1'b0;
  logic                in_ready;
  logic                out_valid;
  clsr_pkg::out_item_t out_item;
  logic                cfg_ready;

  lcd_shadow_scoreboard sb;
  int unsigned tx_idle_pct = 13;
  int unsigned rx_idle_pct = 64;
  int unsigned sent_count  = 0;

  char_lcd_shadow_refresh #(
    .LineLength(LINE_LEN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Receiver: check every accepted result against the oldest prediction,
  // then decide whether to stall on the next cycle.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_item);
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one request: idle at random first, then hold valid and payload
  // until the handshake, and note the request on the accepting edge.
  task automatic send_request(input clsr_pkg::in_item_t req);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(req);
    sent_count++;
  endtask

  task automatic issue(input logic [1:0] op, input logic sel, input logic [4:0] pos,
                       input logic [3:0] idx, input logic [7:0] data, input logic whole);
    clsr_pkg::in_item_t req;
    req.opcode      = op;
    req.line_select = sel;
    req.start_pos   = pos;
    req.char_index  = idx;
    req.data_byte   = data;
    req.force_full  = whole;
    send_request(req);
  endtask

  // Drop valid, let every owed result drain, then write the ownership
  // register while the block is idle, and drop the write before returning.
  task automatic write_config(input logic on);
    in_valid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= on;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_managed(on);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random traffic: mostly whole strings written character by character,
  // with refreshes, clears and some fully random requests mixed in.
  task automatic random_block(input int unsigned n_req);
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    logic        sel;
    logic [4:0]  pos;
    target = sent_count + n_req;
    while (sent_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // Aim at line 2 mostly while it is owned; sometimes try it anyway.
        sel = (sb.line2_on || $urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : 1'b0;
        pos = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                          : 5'($urandom_range(0, 15));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          issue(clsr_pkg::OP_WRITE, sel, pos, 4'(i), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
      end else if (pick < 62) begin
        issue(clsr_pkg::OP_CLEAR, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
      end else if (pick < 88) begin
        issue(clsr_pkg::OP_REFRESH, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              ($urandom_range(0, 3) == 0));
      end else begin
        issue(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part, line 2 not owned yet.
    issue(clsr_pkg::OP_WRITE, 1'b0, 5'd0, 4'd0, 8'hFF, 1'b0);     // first column, top code
    issue(clsr_pkg::OP_WRITE, 1'b1, 5'd3, 4'd2, 8'h41, 1'b1);     // line 2 while unmanaged
    issue(clsr_pkg::OP_WRITE, 1'b0, 5'd31, 4'd15, 8'h7E, 1'b0);   // start column out of range
    issue(clsr_pkg::OP_WRITE, 1'b0, 5'd15, 4'd15, 8'h55, 1'b0);   // past the end of the line
    issue(clsr_pkg::OP_WRITE, 1'b0, 5'd15, 4'd0, 8'h00, 1'b0);    // last column, zero code
    issue(clsr_pkg::OP_REFRESH, 1'b0, 5'd0, 4'd0, 8'h00, 1'b0);
    issue(clsr_pkg::OP_REFRESH, 1'b1, 5'd31, 4'd15, 8'hFF, 1'b0); // nothing left to send
    issue(clsr_pkg::OP_REFRESH, 1'b0, 5'd0, 4'd0, 8'h00, 1'b1);   // forced whole line
    issue(clsr_pkg::OP_CLEAR, 1'b0, 5'd0, 4'd0, 8'h00, 1'b0);
    issue(clsr_pkg::OP_CLEAR, 1'b1, 5'd31, 4'd15, 8'hFF, 1'b1);   // line 2 clear while unmanaged
    issue(OP_UNDEFINED, 1'b1, 5'd31, 4'd15, 8'hFF, 1'b1);
    issue(clsr_pkg::OP_REFRESH, 1'b0, 5'd0, 4'd0, 8'h00, 1'b0);

    // Take line 2 over: the next refresh redraws it whole.
    write_config(1'b1);
    issue(clsr_pkg::OP_REFRESH, 1'b0, 5'd0, 4'd0, 8'h00, 1'b0);
    issue(clsr_pkg::OP_WRITE, 1'b1, 5'd0, 4'd15, 8'hA5, 1'b0);
    issue(clsr_pkg::OP_WRITE, 1'b1, 5'd8, 4'd8, 8'h5A, 1'b0);
    issue(clsr_pkg::OP_REFRESH, 1'b0, 5'd0, 4'd0, 8'h00, 1'b0);
    issue(clsr_pkg::OP_REFRESH, 1'b0, 5'd0, 4'd0, 8'h00, 1'b1);
    // Releasing and retaking line 2 re-arms the full redraw.
    write_config(1'b0);
    write_config(1'b1);
    issue(clsr_pkg::OP_REFRESH, 1'b0, 5'd0, 4'd0, 8'h00, 1'b0);
    issue(clsr_pkg::OP_WRITE, 1'b1, 5'd16, 4'd0, 8'h30, 1'b0);

    // Sender idles lightly, receiver stalls often.
    random_block(65);
    write_config(1'b0);
    random_block(65);

    // Swap: sender idles often, receiver rarely stalls.
    write_config(1'b1);
    tx_idle_pct = 64;
    rx_idle_pct = 13;
    random_block(65);
    write_config(1'b1);
    random_block(65);

    // Full rate on both sides.
    write_config(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_block(65);
    write_config(1'b1);
    random_block(65);

    // Drain, then allow a little extra time for any stray result.
    in_valid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_count() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
